/* rtl/cosq15_pkg.sv */
// ---------------------------------------------------------------------------
// cosq15_pkg: shared types and constants for the table-interpolated cosine
// Elaboration-time sine table generator in exact integer arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package cosq15_pkg;

  typedef logic [14:0]        angle_t;
  typedef logic signed [15:0] sample_t;

  localparam angle_t        QUARTER_TURN = 15'h2000;
  localparam logic [15:0]   FRACT_ONE    = 16'h8000;
  localparam logic [63:0]   PI_Q62       = 64'hC90FDAA22168C235;
  localparam logic [63:0]   LO32         = 64'h00000000FFFFFFFF;

  // floor(a * b / 2^62), kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // floor(num / den) by restoring shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = 64'd0;
    rem = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767 * sin(2*pi*k / 2^tbl_bits)), half away from zero
  function automatic sample_t rom_entry(input int unsigned k, input int unsigned tbl_bits);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] sh;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] dv;
    logic        neg;
    logic        done;
    n     = 64'd1 << tbl_bits;
    m     = 64'(k) & (n - 64'd1);
    sh    = 64'(tbl_bits) - 64'd1;
    neg   = 1'b0;
    done  = 1'b0;
    if (m >= (n >> 1)) begin
      neg = 1'b1;
      m   = m - (n >> 1);
    end
    if (m > (n >> 2)) begin
      m = (n >> 1) - m;
    end
    theta = (((PI_Q62 >> 32) * m) << (64'd32 - sh)) + (((PI_Q62 & LO32) * m) >> sh);
    x2    = mul_q62(theta, theta);
    term  = theta;
    sum   = theta;
    for (int j = 1; j < 40; j++) begin
      if (!done) begin
        dv   = 64'(2 * j) * 64'(2 * j + 1);
        term = udiv64(mul_q62(term, x2), dv);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((j & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    v = mul_q62(sum, 64'd32767 << 32);
    r = (v + 64'h0000000080000000) >> 32;
    if (neg) begin
      r = 64'd0 - r;
    end
    return sample_t'(r[15:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/cosine_q15_table_interpolation.sv */
// ---------------------------------------------------------------------------
// cosine_q15_table_interpolation: Q1.15 cosine by sine-table interpolation
// Quarter-turn offset, two-entry ROM lookup, two-step linear interpolation.
// ---------------------------------------------------------------------------
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, in_angle     | in
//  result  | out_valid, out_stall, out_cos_value | out
//
//  Three-stage pipeline: registered ROM read, two products, final sum.
//  One angle per cycle while the result side does not stall; the result is
//  registered after the synchronous table read, the products and the sum.
//  Table: 2^(15-INDEX_SHIFT)+1 entries, built at elaboration.
//  A stall on the result side holds the full stage and backs up stage by
//  stage; empty stages keep filling. Reset empties all stages.
// ---------------------------------------------------------------------------
`default_nettype none

module cosine_q15_table_interpolation #(
  parameter int unsigned INDEX_SHIFT = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cosq15_pkg::angle_t   in_angle,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cosq15_pkg::sample_t       out_cos_value
);

  localparam int unsigned TBL_BITS = 15 - INDEX_SHIFT;
  localparam int unsigned TBL_LEN  = 1 << TBL_BITS;

  // constant sine table
  cosq15_pkg::sample_t rom_tbl [TBL_LEN + 1];

  for (genvar k = 0; k <= TBL_LEN; k++) begin : g_rom
    localparam cosq15_pkg::sample_t ENTRY = cosq15_pkg::rom_entry(k, TBL_BITS);
    assign rom_tbl[k] = ENTRY;
  end

  // stage enables
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // stage 1: address and fraction
  cosq15_pkg::angle_t     x;
  logic [TBL_BITS:0]      addr_a;
  logic [TBL_BITS:0]      addr_b;
  logic [14:0]            fract;

  assign x      = in_angle + cosq15_pkg::QUARTER_TURN;
  assign addr_a = {1'b0, x[14:INDEX_SHIFT]};
  assign addr_b = addr_a + {{TBL_BITS{1'b0}}, 1'b1};
  assign fract  = {x[INDEX_SHIFT-1:0], {TBL_BITS{1'b0}}};

  cosq15_pkg::sample_t a_r, b_r;
  logic [14:0]         fract_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      a_r     <= rom_tbl[addr_a];
      b_r     <= rom_tbl[addr_b];
      fract_r <= fract;
    end
  end

  // stage 2: both products
  logic signed [16:0] wa;
  logic signed [16:0] wb;
  logic signed [32:0] prod_a;
  logic signed [32:0] prod_b;
  cosq15_pkg::sample_t t_nxt, t_r;
  logic signed [31:0] fb_nxt, fb_r;

  assign wa     = 17'(cosq15_pkg::FRACT_ONE - {1'b0, fract_r});
  assign wb     = {2'b00, fract_r};
  assign prod_a = wa * a_r;
  assign prod_b = wb * b_r;
  assign t_nxt  = prod_a[31:16];
  assign fb_nxt = prod_b[31:0];

  always_ff @(posedge clk) begin
    if (en2) begin
      t_r  <= t_nxt;
      fb_r <= fb_nxt;
    end
  end

  // stage 3: sum, drop 16 fraction bits, double
  cosq15_pkg::sample_t u;
  cosq15_pkg::sample_t cos_nxt, cos_r;

  assign u       = t_r + fb_r[31:16];
  assign cos_nxt = {u[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en3) begin
      cos_r <= cos_nxt;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign out_valid     = v3_r;
  assign out_cos_value = cos_r;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the table-interpolated Q1.15 cosine
// Drives angles through the valid/stall input port and predicts each cosine
// from a locally built sine table and the same two-step truncating
// interpolation. A scoreboard matches every output transaction in order
// while both sides idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INDEX_SHIFT    = 6;
  localparam int unsigned TBL_BITS       = 15 - INDEX_SHIFT;
  localparam int unsigned TBL_LEN        = 1 << TBL_BITS;
  localparam int unsigned FRACT_MASK     = (1 << INDEX_SHIFT) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam real         PI_R           = 3.14159265358979323846;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  cosq15_pkg::angle_t  in_angle  = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  cosq15_pkg::sample_t out_cos_value;

  cosq15_pkg::sample_t sine_rom [0:TBL_LEN];
  cosq15_pkg::sample_t cos_expect_q [$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  cosine_q15_table_interpolation #(
    .INDEX_SHIFT(INDEX_SHIFT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cos_value(out_cos_value)
  );

  always #6 clk = ~clk;

  // round(32767 * sin(2*pi*k/N)), folded to the first quadrant so that
  // mirrored entries match exactly
  function automatic cosq15_pkg::sample_t sine_sample(input int unsigned k);
    int unsigned m;
    bit          neg;
    real         s;
    int          r;
    m   = k % TBL_LEN;
    neg = 1'b0;
    if (m >= TBL_LEN / 2) begin
      neg = 1'b1;
      m   = m - TBL_LEN / 2;
    end
    if (m > TBL_LEN / 4) begin
      m = TBL_LEN / 2 - m;
    end
    s = 32767.0 * $sin(PI_R * real'(m) / real'(TBL_LEN / 2));
    r = int'($floor(s + 0.5));
    return neg ? cosq15_pkg::sample_t'(-r) : cosq15_pkg::sample_t'(r);
  endfunction

  function automatic cosq15_pkg::sample_t predict_cos(input cosq15_pkg::angle_t ang);
    cosq15_pkg::angle_t x;
    int unsigned        idx;
    longint             f;
    longint             a;
    longint             b;
    longint             t;
    longint             u;
    x   = ang + cosq15_pkg::QUARTER_TURN;
    idx = int'(x) >> INDEX_SHIFT;
    f   = longint'(int'(x) & FRACT_MASK) << TBL_BITS;
    a   = longint'(sine_rom[idx]);
    b   = longint'(sine_rom[idx + 1]);
    t   = ((longint'(cosq15_pkg::FRACT_ONE) - f) * a) >>> 16;
    t   = longint'($signed(t[15:0]));
    u   = (t * 65536 + f * b) >>> 16;
    return cosq15_pkg::sample_t'({u[14:0], 1'b0});
  endfunction

  // hold angle until accepted; insert random idle cycles ahead of it
  task automatic send_angle(input cosq15_pkg::angle_t ang);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (cos_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic cosq15_pkg::angle_t random_angle();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(0, 3);
    base = $urandom_range(0, TBL_LEN - 1) << INDEX_SHIFT;
    case (pick)
      0: begin
        // fraction at either end of its range
        return cosq15_pkg::angle_t'(base | (($urandom() & 1) ? FRACT_MASK : 0));
      end
      1: begin
        // region that wraps past a full turn
        return cosq15_pkg::angle_t'($urandom_range(32'h6000, 32'h7FFF));
      end
      default: begin
        return cosq15_pkg::angle_t'($urandom_range(0, 32'h7FFF));
      end
    endcase
  endfunction

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // field extremes, last table entry, quarter-turn wrap, fraction extremes
  task automatic test_directed_angles();
    cosq15_pkg::angle_t dir_list [20] = '{
      15'h0000, 15'h0001, 15'h7FFF, 15'h1FFF, 15'h2000,
      15'h3FFF, 15'h4000, 15'h5FBF, 15'h5FC0, 15'h5FFF,
      15'h6000, 15'h6001, 15'h7FC0, 15'h7FBF, 15'h5555,
      15'h2AAA, 15'h0FFF, 15'h103F, 15'h003F, 15'h0040
    };
    set_idling(0, 0);
    foreach (dir_list[i]) begin
      send_angle(dir_list[i]);
    end
    wait_for_drain();
  endtask

  task automatic test_random_angles(input int unsigned count,
                                    input int unsigned src_pct,
                                    input int unsigned sink_pct);
    set_idling(src_pct, sink_pct);
    repeat (count) begin
      send_angle(random_angle());
    end
  endtask

  // let the pipeline empty completely, then restart with a back-to-back burst
  task automatic test_drain_then_burst();
    set_idling(0, 13);
    repeat (40) begin
      send_angle(random_angle());
    end
    wait_for_drain();
    set_idling(0, 0);
    repeat (40) begin
      send_angle(random_angle());
    end
  endtask

  // scoreboard: check output transactions first, then record input ones
  always @(posedge clk) begin : scoreboard
    cosq15_pkg::sample_t want;
    if (out_valid && !out_stall) begin
      if (cos_expect_q.size() == 0) begin
        $error("cos_value: unexpected result %0d with nothing pending", out_cos_value);
        mismatch_count++;
      end else begin
        want = cos_expect_q.pop_front();
        if (out_cos_value !== want) begin
          $error("cos_value mismatch: expected %0d, actual %0d", want, out_cos_value);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      cos_expect_q.push_back(predict_cos(in_angle));
    end
    if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int unsigned k = 0; k <= TBL_LEN; k++) begin
      sine_rom[k] = sine_sample(k);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_angles();
    test_random_angles(240, 0, 0);
    test_random_angles(240, 70, 0);
    test_random_angles(240, 0, 70);
    test_drain_then_burst();
    test_random_angles(240, 13, 13);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cos_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
